@@ rtl/fkin_pkg.sv @@
// Shared constants, tables and types of the serial arm forward kinematics unit.
package fkin_pkg;

    localparam int NUM_JOINTS  = 5;
    localparam int ANGLE_W     = 15;
    localparam int LEN_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int ROT_OUT_W   = 16;
    localparam int POS_OUT_W   = 15;

    // Angle units: 1/64 degree
    localparam int TURN_UNITS  = 23040;
    localparam int QUAD_UNITS  = 5760;

    // r * 2^30 / 5760 = r * 2^23 / 45; r / 45 by reciprocal 1456 / 2^16
    localparam int QUAD_DIV    = 45;
    localparam int RECIP_DIV   = 1456;
    localparam int RECIP_SH    = 16;
    localparam int U_FRAC_W    = 23;

    // Pipeline depths
    localparam int LANE_LAT    = 15;
    localparam int JOINT_LAT   = 4;
    localparam int TOTAL_LAT   = LANE_LAT + JOINT_LAT * NUM_JOINTS + 1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_ONE   = 3'd0,
        REG_LINK_TWO   = 3'd1,
        REG_LINK_THREE = 3'd2,
        REG_LINK_FOUR  = 3'd3,
        REG_LINK_FIVE  = 3'd4
    } t_cfg_reg;

    typedef logic [LEN_W-1:0] t_len_arr [NUM_JOINTS];
    localparam t_len_arr LEN_RST = '{10'd76, 10'd125, 10'd125, 10'd60, 10'd132};

    // Sine polynomial in Q30, Horner form over u^2
    localparam logic signed [31:0] P_INIT = 32'sd172272;
    typedef logic signed [31:0] t_horner [4];
    localparam t_horner HORNER_C = '{-32'sd5026995, 32'sd85569306,
                                     -32'sd693598668, 32'sd1686629713};

    // floor(j * 2^23 / 45) for j = 0..44
    typedef logic [U_FRAC_W-1:0] t_ufrac_tbl [QUAD_DIV];

    function automatic t_ufrac_tbl build_ufrac();
        t_ufrac_tbl tb;
        for (int j = 0; j < QUAD_DIV; j++) begin
            tb[j] = U_FRAC_W'((64'(j) << U_FRAC_W) / QUAD_DIV);
        end
        return tb;
    endfunction

    localparam t_ufrac_tbl U_FRAC = build_ufrac();

endpackage

@@ rtl/fkin_sine.sv @@
// Pipelined sine lane: angle in 1/64 degree to a signed fixed-point sine or cosine.
module fkin_sine #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_cos,
    input  logic signed [14:0]              i_angle,
    output logic signed [FRACTION_BITS+1:0] o_val
);

    localparam logic [32:0] ONE_Q   = 33'(1) << FRACTION_BITS;
    localparam logic [32:0] HALF_FX = 33'(1) << (29 - FRACTION_BITS);
    localparam logic [62:0] HALF_30 = 63'(1) << 29;

    // Stage 1: fold into one quadrant
    logic signed [15:0] a16;
    logic [15:0]        m16;
    logic [14:0]        m;
    logic [1:0]         q;
    logic [12:0]        r;
    logic [12:0]        rp;

    always_comb begin
        a16 = {i_angle[14], i_angle} + (i_cos ? 16'sd5760 : 16'sd0);
        m16 = a16[15] ? 16'(a16 + 16'sd23040) : 16'(a16);
        m   = m16[14:0];
        if (m >= 15'd17280) begin
            q = 2'd3;
            r = 13'(m - 15'd17280);
        end else if (m >= 15'd11520) begin
            q = 2'd2;
            r = 13'(m - 15'd11520);
        end else if (m >= 15'd5760) begin
            q = 2'd1;
            r = 13'(m - 15'd5760);
        end else begin
            q = 2'd0;
            r = 13'(m);
        end
        rp = q[0] ? 13'(13'd5760 - r) : r;
    end

    logic [12:0] r_rp [1:2];
    logic        r_neg [1:14];
    logic [7:0]  r_k0;
    logic [30:0] r_u [3:13];
    logic [61:0] r_uu;
    logic [30:0] r_u2 [5:11];
    logic [61:0] r_hp [4];
    logic        r_hn [4];
    logic signed [31:0] r_p [1:4];
    logic [61:0] r_fm;
    logic        r_fn;

    // Stage 3: u = floor(rp * 2^23 / 45) from quotient and remainder
    logic [12:0] rem;
    logic [7:0]  k;
    logic [5:0]  j;

    always_comb begin
        rem = r_rp[2] - 13'(13'(r_k0) * 13'(fkin_pkg::QUAD_DIV));
        if (rem >= 13'(fkin_pkg::QUAD_DIV)) begin
            k = r_k0 + 8'd1;
            j = 6'(rem - 13'(fkin_pkg::QUAD_DIV));
        end else begin
            k = r_k0;
            j = 6'(rem);
        end
    end

    // Horner operands
    logic signed [31:0] p_in [4];
    logic [30:0]        p_abs [4];
    logic [31:0]        h_mr [4];

    always_comb begin
        p_in[0] = fkin_pkg::P_INIT;
        for (int i = 1; i < 4; i++) begin
            p_in[i] = r_p[i];
        end
        for (int i = 0; i < 4; i++) begin
            p_abs[i] = p_in[i][31] ? 31'(-p_in[i]) : 31'(p_in[i]);
            h_mr[i]  = 32'((63'(r_hp[i]) + HALF_30) >> 30);
        end
    end

    // Final scale, clamp and quadrant sign
    logic [30:0] f_abs;
    logic [32:0] f_mr;
    logic [32:0] f_mag;
    logic [FRACTION_BITS:0] f_s;

    always_comb begin
        f_abs = r_p[4][31] ? 31'(-r_p[4]) : 31'(r_p[4]);
        f_mr  = 33'((63'(r_fm) + HALF_30) >> 30);
        f_mag = (f_mr + HALF_FX) >> (30 - FRACTION_BITS);
        if (r_fn) begin
            f_s = '0;
        end else if (f_mag > ONE_Q) begin
            f_s = (FRACTION_BITS+1)'(ONE_Q);
        end else begin
            f_s = (FRACTION_BITS+1)'(f_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[1]  <= rp;
            r_neg[1] <= q[1];
            for (int s = 2; s <= 14; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            r_rp[2] <= r_rp[1];
            r_k0    <= 8'((24'(r_rp[1]) * 24'(fkin_pkg::RECIP_DIV)) >> fkin_pkg::RECIP_SH);
            r_u[3]  <= {k, 23'b0} + 31'(fkin_pkg::U_FRAC[j]);
            for (int s = 4; s <= 13; s++) begin
                r_u[s] <= r_u[s-1];
            end
            r_uu    <= 62'(r_u[3]) * 62'(r_u[3]);
            r_u2[5] <= 31'((63'(r_uu) + HALF_30) >> 30);
            for (int s = 6; s <= 11; s++) begin
                r_u2[s] <= r_u2[s-1];
            end
            for (int i = 0; i < 4; i++) begin
                r_hp[i]  <= 62'(p_abs[i]) * 62'(r_u2[5+2*i]);
                r_hn[i]  <= p_in[i][31];
                r_p[i+1] <= fkin_pkg::HORNER_C[i] +
                            (r_hn[i] ? -$signed(h_mr[i]) : $signed(h_mr[i]));
            end
            r_fm  <= 62'(f_abs) * 62'(r_u[13]);
            r_fn  <= r_p[4][31];
            o_val <= r_neg[14] ? -$signed({1'b0, f_s}) : $signed({1'b0, f_s});
        end
    end

endmodule

@@ rtl/fkin_joint.sv @@
// One joint of the chain: column rotation of the running pose, then link translation.
module fkin_joint #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_about_z,
    input  logic signed [FRACTION_BITS+1:0]  i_sin,
    input  logic signed [FRACTION_BITS+1:0]  i_cos,
    input  logic [9:0]                       i_len,
    input  logic signed [FRACTION_BITS+2:0]  i_r [3][3],
    input  logic signed [FRACTION_BITS+16:0] i_t [3],
    output logic signed [FRACTION_BITS+2:0]  o_r [3][3],
    output logic signed [FRACTION_BITS+16:0] o_t [3]
);

    localparam int RW  = FRACTION_BITS + 3;
    localparam int PW  = 2 * FRACTION_BITS + 5;
    localparam int SW  = PW + 1;
    localparam int TPW = RW + 11;
    localparam int TW  = FRACTION_BITS + 17;
    localparam logic [SW-1:0] HALF = SW'(1) << (FRACTION_BITS - 1);

    function automatic logic signed [RW-1:0] rnd(input logic signed [SW-1:0] x);
        logic [SW-1:0] mag;
        logic [SW-1:0] qv;
        mag = x[SW-1] ? SW'(-x) : SW'(x);
        qv  = (mag + HALF) >> FRACTION_BITS;
        return x[SW-1] ? -$signed(qv[RW-1:0]) : $signed(qv[RW-1:0]);
    endfunction

    // Rotation about y runs with the sine negated
    logic signed [FRACTION_BITS+1:0] s_eff;
    logic signed [RW-1:0]            rb_in [3];

    always_comb begin
        s_eff = i_about_z ? i_sin : -i_sin;
        for (int i = 0; i < 3; i++) begin
            rb_in[i] = i_about_z ? i_r[i][1] : i_r[i][2];
        end
    end

    logic signed [PW-1:0]  r_pca [3];
    logic signed [PW-1:0]  r_psb [3];
    logic signed [PW-1:0]  r_pcb [3];
    logic signed [PW-1:0]  r_psa [3];
    logic signed [RW-1:0]  r_ra [3][3];
    logic signed [TW-1:0]  r_ta [3];
    logic                  r_za;
    logic signed [RW-1:0]  r_rb [3][3];
    logic signed [TW-1:0]  r_tb [3];
    logic signed [TPW-1:0] r_tp [3];
    logic signed [RW-1:0]  r_rc [3][3];
    logic signed [TW-1:0]  r_tc [3];
    logic signed [RW-1:0]  r_rd [3][3];
    logic signed [TW-1:0]  r_td [3];

    // Rounded sums of the product pairs
    logic signed [RW-1:0] na [3];
    logic signed [RW-1:0] nb [3];
    logic signed [RW-1:0] n_rb [3][3];

    always_comb begin
        n_rb = r_ra;
        for (int i = 0; i < 3; i++) begin
            na[i] = rnd(SW'(r_pca[i]) + SW'(r_psb[i]));
            nb[i] = rnd(SW'(r_pcb[i]) - SW'(r_psa[i]));
            n_rb[i][0] = na[i];
            if (r_za) begin
                n_rb[i][1] = nb[i];
            end else begin
                n_rb[i][2] = nb[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products
            for (int i = 0; i < 3; i++) begin
                r_pca[i] <= i_cos * i_r[i][0];
                r_psb[i] <= s_eff * rb_in[i];
                r_pcb[i] <= i_cos * rb_in[i];
                r_psa[i] <= s_eff * i_r[i][0];
            end
            r_ra <= i_r;
            r_ta <= i_t;
            r_za <= i_about_z;
            // rotated columns
            r_rb <= n_rb;
            r_tb <= r_ta;
            // translation along the new z column
            for (int i = 0; i < 3; i++) begin
                r_tp[i] <= r_rb[i][2] * $signed({1'b0, i_len});
            end
            r_rc <= r_rb;
            r_tc <= r_tb;
            r_rd <= r_rc;
            for (int i = 0; i < 3; i++) begin
                r_td[i] <= r_tc[i] + TW'(r_tp[i]);
            end
        end
    end

    assign o_r = r_rd;
    assign o_t = r_td;

endmodule

@@ rtl/serial_arm_forward_kinematics_unit.sv @@
// Top level of the five-joint serial arm forward kinematics unit.
//
// Usage:
//   Input channel (i_valid / o_ready) carries five joint angles in 1/64 degree.
//   Output channel (o_valid / i_ready) carries the 3x3 rotation in Q1.14 and the
//   position in Q10.4 millimetres, saturated at the field limits.
//   Link lengths are written on i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Throughput: one request per cycle unless a stall holds the pipeline. Ten sine
//   lanes (sine and cosine of every joint) run side by side, and five joint
//   stages chain the rotations and translations.
// Path: from input acceptance to o_valid a request passes the sine lanes, the
//   joint stages in turn and the output rounding and saturation register.
// Reset: synchronous, active low; clears the pipeline valid bits and loads the
//   default link lengths. No clearing pass is needed.
// Stall: when a result waits with i_ready low, the whole pipeline holds and
//   o_ready drops; nothing is lost or repeated.
module serial_arm_forward_kinematics_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [14:0] i_base_angle,
    input  logic signed [14:0] i_shoulder_angle,
    input  logic signed [14:0] i_elbow_angle,
    input  logic signed [14:0] i_wrist_pitch_angle,
    input  logic signed [14:0] i_wrist_roll_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_rot_r0c0,
    output logic signed [15:0] o_rot_r0c1,
    output logic signed [15:0] o_rot_r0c2,
    output logic signed [15:0] o_rot_r1c0,
    output logic signed [15:0] o_rot_r1c1,
    output logic signed [15:0] o_rot_r1c2,
    output logic signed [15:0] o_rot_r2c0,
    output logic signed [15:0] o_rot_r2c1,
    output logic signed [15:0] o_rot_r2c2,
    output logic signed [14:0] o_pos_x,
    output logic signed [14:0] o_pos_y,
    output logic signed [14:0] o_pos_z
);

    localparam int NJ     = fkin_pkg::NUM_JOINTS;
    localparam int LAT    = fkin_pkg::TOTAL_LAT;
    localparam int TRIG_W = FRACTION_BITS + 2;
    localparam int RW     = FRACTION_BITS + 3;
    localparam int TW     = FRACTION_BITS + 17;
    localparam int DOWN   = (FRACTION_BITS > 14) ? FRACTION_BITS - 14 : 0;
    localparam int UP     = (FRACTION_BITS < 14) ? 14 - FRACTION_BITS : 0;
    localparam int CW     = RW + UP;
    localparam logic [RW-1:0] HALF_DN  = (DOWN > 0) ? RW'(1) << (DOWN - 1) : '0;
    localparam logic [TW-1:0] HALF_POS = TW'(1) << (FRACTION_BITS - 5);
    localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRACTION_BITS;

    // Pipeline advance: output register empty or being taken
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Link length registers
    logic [9:0] r_len [NJ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NJ; i++) begin
                r_len[i] <= fkin_pkg::LEN_RST[i];
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fkin_pkg::REG_LINK_ONE:   r_len[0] <= i_cfg_data;
                fkin_pkg::REG_LINK_TWO:   r_len[1] <= i_cfg_data;
                fkin_pkg::REG_LINK_THREE: r_len[2] <= i_cfg_data;
                fkin_pkg::REG_LINK_FOUR:  r_len[3] <= i_cfg_data;
                fkin_pkg::REG_LINK_FIVE:  r_len[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [14:0] ang_in [NJ];

    assign ang_in[0] = i_base_angle;
    assign ang_in[1] = i_shoulder_angle;
    assign ang_in[2] = i_elbow_angle;
    assign ang_in[3] = i_wrist_pitch_angle;
    assign ang_in[4] = i_wrist_roll_angle;

    // Running pose between joint stages; stage k handles joint NJ-1-k
    logic signed [RW-1:0]     jr [NJ+1][3][3];
    logic signed [TW-1:0]     jt [NJ+1][3];
    logic signed [TRIG_W-1:0] lane_sin [NJ];
    logic signed [TRIG_W-1:0] lane_cos [NJ];
    logic signed [14:0]       lane_ang [NJ];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                jr[0][i][j] = (i == j) ? ONE_R : '0;
            end
            jt[0][i] = '0;
        end
    end

    for (genvar k = 0; k < NJ; k++) begin : g_step
        // Angle waits until the pose reaches this joint
        if (k == 0) begin : g_direct
            assign lane_ang[k] = ang_in[NJ-1-k];
        end else begin : g_delay
            logic signed [14:0] r_adly [fkin_pkg::JOINT_LAT*k];

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_adly[0] <= ang_in[NJ-1-k];
                    for (int d = 1; d < fkin_pkg::JOINT_LAT * k; d++) begin
                        r_adly[d] <= r_adly[d-1];
                    end
                end
            end

            assign lane_ang[k] = r_adly[fkin_pkg::JOINT_LAT*k-1];
        end

        fkin_sine #(.FRACTION_BITS(FRACTION_BITS)) u_sin (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_cos   (1'b0),
            .i_angle (lane_ang[k]),
            .o_val   (lane_sin[k])
        );

        fkin_sine #(.FRACTION_BITS(FRACTION_BITS)) u_cos (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_cos   (1'b1),
            .i_angle (lane_ang[k]),
            .o_val   (lane_cos[k])
        );

        fkin_joint #(.FRACTION_BITS(FRACTION_BITS)) u_joint (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_about_z ((k == 0) || (k == NJ - 1)),
            .i_sin     (lane_sin[k]),
            .i_cos     (lane_cos[k]),
            .i_len     (r_len[NJ-1-k]),
            .i_r       (jr[k]),
            .i_t       (jt[k]),
            .o_r       (jr[k+1]),
            .o_t       (jt[k+1])
        );
    end

    // Output rounding and saturation
    function automatic logic signed [15:0] rot_out(input logic signed [RW-1:0] v);
        logic [RW-1:0]        mag;
        logic [RW-1:0]        rq;
        logic signed [RW-1:0] sv;
        logic signed [CW-1:0] w;
        mag = v[RW-1] ? RW'(-v) : RW'(v);
        rq  = (mag + HALF_DN) >> DOWN;
        sv  = v[RW-1] ? -$signed(rq) : $signed(rq);
        w   = CW'(sv) <<< UP;
        if (w > $signed(CW'(16384))) begin
            return 16'sd16384;
        end else if (w < -$signed(CW'(16384))) begin
            return -16'sd16384;
        end
        return 16'(w);
    endfunction

    function automatic logic signed [14:0] pos_out(input logic signed [TW-1:0] t);
        logic [TW-1:0] mag;
        logic [TW-1:0] qv;
        logic [14:0]   qm;
        mag = t[TW-1] ? TW'(-t) : TW'(t);
        qv  = (mag + HALF_POS) >> (FRACTION_BITS - 4);
        qm  = (qv > TW'(16383)) ? 15'd16383 : qv[14:0];
        return t[TW-1] ? -$signed(qm) : $signed(qm);
    endfunction

    logic signed [15:0] r_rot [9];
    logic signed [14:0] r_pos [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_rot[i*3+j] <= rot_out(jr[NJ][i][j]);
                end
                r_pos[i] <= pos_out(jt[NJ][i]);
            end
        end
    end

    assign o_rot_r0c0 = r_rot[0];
    assign o_rot_r0c1 = r_rot[1];
    assign o_rot_r0c2 = r_rot[2];
    assign o_rot_r1c0 = r_rot[3];
    assign o_rot_r1c1 = r_rot[4];
    assign o_rot_r1c2 = r_rot[5];
    assign o_rot_r2c0 = r_rot[6];
    assign o_rot_r2c1 = r_rot[7];
    assign o_rot_r2c2 = r_rot[8];
    assign o_pos_x    = r_pos[0];
    assign o_pos_y    = r_pos[1];
    assign o_pos_z    = r_pos[2];

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rot_r0c0 <= 16'sd16384 && o_rot_r0c0 >= -16'sd16384 &&
                     o_rot_r1c1 <= 16'sd16384 && o_rot_r1c1 >= -16'sd16384 &&
                     o_rot_r2c2 <= 16'sd16384 && o_rot_r2c2 >= -16'sd16384))
        else $error("rotation entry beyond saturation limit");

    a_pos_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_x != 15'h4000 && o_pos_y != 15'h4000 && o_pos_z != 15'h4000))
        else $error("position not saturated symmetrically");
`endif

endmodule

@@ dv/tb_serial_arm_forward_kinematics_unit.sv @@
// Self-checking testbench of the serial arm forward kinematics unit.
module tb_serial_arm_forward_kinematics_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam int N_RANDOM = 880;
    localparam logic [2:0] UNMAPPED_IDX = 3'd7;

    typedef struct {
        logic signed [14:0] ang [5];
    } t_pose_req;

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [14:0] pos [3];
    } t_pose;

    typedef struct {
        logic signed [14:0] ang [5];
        logic               known;
        logic signed [15:0] rot [9];
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [9:0]         i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [14:0] i_base_angle;
    logic signed [14:0] i_shoulder_angle;
    logic signed [14:0] i_elbow_angle;
    logic signed [14:0] i_wrist_pitch_angle;
    logic signed [14:0] i_wrist_roll_angle;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_rot [9];
    logic signed [14:0] o_pos_x, o_pos_y, o_pos_z;

    // Predictor copy of the link registers
    logic [9:0] link_mm [5];
    t_pose      pose_q [$];
    int         n_fail;
    bit         rx_hold;

    serial_arm_forward_kinematics_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_base_angle        (i_base_angle),
        .i_shoulder_angle    (i_shoulder_angle),
        .i_elbow_angle       (i_elbow_angle),
        .i_wrist_pitch_angle (i_wrist_pitch_angle),
        .i_wrist_roll_angle  (i_wrist_roll_angle),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_rot_r0c0          (o_rot[0]),
        .o_rot_r0c1          (o_rot[1]),
        .o_rot_r0c2          (o_rot[2]),
        .o_rot_r1c0          (o_rot[3]),
        .o_rot_r1c1          (o_rot[4]),
        .o_rot_r1c2          (o_rot[5]),
        .o_rot_r2c0          (o_rot[6]),
        .o_rot_r2c1          (o_rot[7]),
        .o_rot_r2c2          (o_rot[8]),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_pos_z             (o_pos_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round to nearest, ties away from zero
    function automatic longint rnd_shift(longint x, int sh);
        longint m;
        m = (x < 0) ? -x : x;
        if (sh > 0) m = (m + (longint'(1) << (sh - 1))) >>> sh;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint rnd_mul(longint a, longint b, int sh);
        return rnd_shift(a * b, sh);
    endfunction

    function automatic longint quadrant_sine(int r);
        longint u, u2, p, s;
        u  = (longint'(r) << 30) / fkin_pkg::QUAD_UNITS;
        u2 = rnd_mul(u, u, 30);
        p  = 172272;
        p  = -5026995 + rnd_mul(p, u2, 30);
        p  = 85569306 + rnd_mul(p, u2, 30);
        p  = -693598668 + rnd_mul(p, u2, 30);
        p  = 1686629713 + rnd_mul(p, u2, 30);
        s  = rnd_shift(rnd_mul(p, u, 30), 30 - FRAC);
        if (s < 0) s = 0;
        if (s > (longint'(1) << FRAC)) s = longint'(1) << FRAC;
        return s;
    endfunction

    function automatic longint angle_sine(int a);
        int m, q, r;
        longint s;
        m = ((a % fkin_pkg::TURN_UNITS) + fkin_pkg::TURN_UNITS) % fkin_pkg::TURN_UNITS;
        q = m / fkin_pkg::QUAD_UNITS;
        r = m % fkin_pkg::QUAD_UNITS;
        s = (q % 2 == 1) ? quadrant_sine(fkin_pkg::QUAD_UNITS - r) : quadrant_sine(r);
        return (q >= 2) ? -s : s;
    endfunction

    function automatic longint sat(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // Chain the joint transforms, wrist roll first
    function automatic t_pose solve_pose(t_pose_req rq);
        longint rm [3][3];
        longint tv [3];
        longint s, c, a0, a1;
        int     axis_z, ang;
        t_pose  res;
        for (int i = 0; i < 3; i++) begin
            tv[i] = 0;
            for (int j = 0; j < 3; j++) rm[i][j] = (i == j) ? (longint'(1) << FRAC) : 0;
        end
        for (int k = 4; k >= 0; k--) begin
            ang    = int'(rq.ang[k]);
            axis_z = (k == 4 || k == 0);
            s = angle_sine(ang);
            c = angle_sine(ang + fkin_pkg::QUAD_UNITS);
            for (int i = 0; i < 3; i++) begin
                if (axis_z) begin
                    a0 = rm[i][0];
                    a1 = rm[i][1];
                    rm[i][0] = rnd_shift(c * a0 + s * a1, FRAC);
                    rm[i][1] = rnd_shift(c * a1 - s * a0, FRAC);
                end else begin
                    a0 = rm[i][0];
                    a1 = rm[i][2];
                    rm[i][0] = rnd_shift(c * a0 - s * a1, FRAC);
                    rm[i][2] = rnd_shift(s * a0 + c * a1, FRAC);
                end
            end
            for (int i = 0; i < 3; i++) tv[i] += rm[i][2] * longint'(link_mm[k]);
        end
        for (int i = 0; i < 9; i++) res.rot[i] = 16'(sat(rm[i / 3][i % 3], 16384));
        for (int i = 0; i < 3; i++) res.pos[i] = 15'(sat(rnd_shift(tv[i], FRAC - 4), 16383));
        return res;
    endfunction

    // Drive one request, optionally after a random gap; valid stays up after acceptance
    task automatic send_pose(t_pose_req rq, bit with_gap);
        int gap;
        gap = with_gap ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_base_angle        <= rq.ang[0];
        i_shoulder_angle    <= rq.ang[1];
        i_elbow_angle       <= rq.ang[2];
        i_wrist_pitch_angle <= rq.ang[3];
        i_wrist_roll_angle  <= rq.ang[4];
        pose_q.insert(pose_q.size(), solve_pose(rq));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic stop_requests();
        i_valid <= 1'b0;
    endtask

    task automatic write_link(fkin_pkg::t_cfg_reg idx, logic [9:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        link_mm[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        stop_requests();
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (fkin_pkg::TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [14:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 15'($urandom);
            1: return 15'($urandom_range(0, 23040) - 11520);
            2: return 15'(($urandom_range(0, 8) - 4) * fkin_pkg::QUAD_UNITS);
            default: return 15'($urandom_range(0, 60) - 30);
        endcase
    endfunction

    // Receiver: random stall per result
    initial begin
        int wait_n;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            if (rx_hold || wait_n > 0) begin
                i_ready <= 1'b0;
                while (rx_hold) @(posedge i_clk);
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_pose ex;
        if (i_rst_n && o_valid && i_ready) begin
            if (pose_q.size() == 0) begin
                $error("result with no request outstanding");
                n_fail++;
            end else begin
                ex = pose_q.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (o_rot[i] !== ex.rot[i]) begin
                        $error("rot_r%0dc%0d expected %0d got %0d", i / 3, i % 3,
                               ex.rot[i], o_rot[i]);
                        n_fail++;
                    end
                end
                if (o_pos_x !== ex.pos[0]) begin
                    $error("pos_x expected %0d got %0d", ex.pos[0], o_pos_x);
                    n_fail++;
                end
                if (o_pos_y !== ex.pos[1]) begin
                    $error("pos_y expected %0d got %0d", ex.pos[1], o_pos_y);
                    n_fail++;
                end
                if (o_pos_z !== ex.pos[2]) begin
                    $error("pos_z expected %0d got %0d", ex.pos[2], o_pos_z);
                    n_fail++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_dir_row  dir_tbl [$];
        t_dir_row  row;
        t_pose_req rq;
        t_pose     ex;
        int        hold_n;
        n_fail    = 0;
        rx_hold   = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_base_angle = '0;
        i_shoulder_angle = '0;
        i_elbow_angle = '0;
        i_wrist_pitch_angle = '0;
        i_wrist_roll_angle = '0;
        for (int k = 0; k < 5; k++) link_mm[k] = fkin_pkg::LEN_RST[k];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: identity and axis-aligned poses have obvious rotations
        row.known = 1'b1;
        row.ang = '{0, 0, 0, 0, 0};
        row.rot = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{0, 0, 0, 0, 11520};
        row.rot = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{-11520, 0, 0, 0, 0};
        row.rot = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        dir_tbl.insert(dir_tbl.size(), row);
        // Two half turns about y cancel
        row.ang = '{0, 11520, -11520, 0, 0};
        row.rot = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        dir_tbl.insert(dir_tbl.size(), row);
        row.known = 1'b0;
        row.ang = '{16383, -16384, 16383, -16384, 16383};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{-16384, 16383, -16384, 16383, -16384};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{5760, 5760, 5760, 5760, 5760};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{-5760, -5760, -5760, -5760, -5760};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{1, -1, 5759, 5761, 11519};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{2880, 1920, -3840, 960, 7000};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{-11521, 11521, 16000, -16000, 0};
        dir_tbl.insert(dir_tbl.size(), row);
        row.ang = '{-1, -1, -1, -1, -1};
        dir_tbl.insert(dir_tbl.size(), row);
        foreach (dir_tbl[n]) begin
            rq.ang = dir_tbl[n].ang;
            if (dir_tbl[n].known) begin
                ex = solve_pose(rq);
                for (int i = 0; i < 9; i++) begin
                    if (ex.rot[i] != dir_tbl[n].rot[i]) begin
                        $error("rot%0d table expected %0d got %0d", i,
                               dir_tbl[n].rot[i], ex.rot[i]);
                        n_fail++;
                    end
                end
            end
            send_pose(rq, 1'b1);
        end
        drain();

        // Link extremes: all maximum drives positions into saturation
        for (int k = 0; k < 5; k++) write_link(fkin_pkg::t_cfg_reg'(k), 10'd1023);
        // Unmapped index must be ignored by the block
        i_cfg_we <= 1'b1;
        i_cfg_idx <= UNMAPPED_IDX;
        i_cfg_data <= 10'd5;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rq.ang = '{0, 0, 0, 0, 0};
        send_pose(rq, 1'b0);
        rq.ang = '{0, 11520, 0, 0, 0};
        send_pose(rq, 1'b0);
        rq.ang = '{2000, 3000, 1000, 500, 0};
        send_pose(rq, 1'b0);
        drain();

        // Random phases across link settings
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 5; k++) begin
                case (ph)
                    0: write_link(fkin_pkg::t_cfg_reg'(k), 10'd0);
                    1: write_link(fkin_pkg::t_cfg_reg'(k), 10'($urandom));
                    2: write_link(fkin_pkg::t_cfg_reg'(k), fkin_pkg::LEN_RST[k]);
                    default: write_link(fkin_pkg::t_cfg_reg'(k),
                                        10'($urandom_range(900, 1023)));
                endcase
            end
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                for (int k = 0; k < 5; k++) rq.ang[k] = rand_angle();
                // Long receiver hold while requests keep coming
                if (ph == 1 && n == 20) begin
                    rx_hold = 1'b1;
                    fork
                        begin
                            hold_n = 120;
                            repeat (hold_n) @(posedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                // Sender pause until all results are back
                if (ph == 2 && n == 100) begin
                    stop_requests();
                    @(posedge i_clk);
                    while (pose_q.size() != 0) @(posedge i_clk);
                end
                send_pose(rq, (n % 64) < 40);
            end
            drain();
        end

        if (n_fail == 0 && pose_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
